@@ sv/sms_send_command_sequencer_unit_macros.svh @@
// Assertion macros for the SMS send command sequencer unit
`ifndef SMS_SEND_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define SMS_SEND_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sms_pkg.sv @@
// Shared types and codes for the SMS send command sequencer
`timescale 1ns / 1ps
package sms_pkg;

  // Field widths
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_INIT     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SET_FMT  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_FMT = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SET_ENC  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_ENC = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SET_NUM  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WAIT_NUM = 4'd6;
  localparam logic [PHASE_W-1:0] PH_SEND     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_WAIT_RES = 4'd8;
  localparam logic [PHASE_W-1:0] PH_DONE     = 4'd9;
  localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd10;

  // Modem response codes
  localparam logic [EVENT_W-1:0] EV_OK      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ERROR   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PROMPT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SENT    = 3'd4;

  // Command request codes
  localparam logic [REQ_W-1:0] REQ_NONE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_FMT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_ENC  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_NUM  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEND_TXT = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd1;
  localparam logic [CFG_W-1:0]     TIMEOUT_LIMIT_RST = 8'd3;
  localparam logic [CFG_W-1:0]     RETRY_LIMIT_RST   = 8'd3;

  // Sequencer state carried between poll ticks
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CNT_W-1:0]   fmt_timeouts;
    logic [CNT_W-1:0]   enc_timeouts;
    logic [CNT_W-1:0]   num_timeouts;
    logic [CNT_W-1:0]   retries_used;
    logic               sent;
  } sms_regs_t;

  // One poll tick
  typedef struct packed {
    logic               cmd_accepted;
    logic [EVENT_W-1:0] event_code;
    logic               event_present;
  } sms_tick_t;

  // One result
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               failed;
    logic               finished;
    logic               event_taken;
    logic [REQ_W-1:0]   cmd_request;
  } sms_res_t;

endpackage

@@ sv/sms_step.sv @@
// Next-state and result logic for one poll tick of the sequencer
`timescale 1ns / 1ps
module sms_step (
  input  sms_pkg::sms_regs_t       st,
  input  sms_pkg::sms_tick_t       tick,
  input  logic [sms_pkg::CFG_W-1:0] timeout_limit,
  input  logic [sms_pkg::CFG_W-1:0] retry_limit,
  output sms_pkg::sms_regs_t       st_nxt,
  output sms_pkg::sms_res_t        res
);
  import sms_pkg::*;

  logic [CNT_W-1:0] fmt_inc;
  logic [CNT_W-1:0] enc_inc;
  logic [CNT_W-1:0] num_inc;
  logic             fmt_hit;
  logic             enc_hit;
  logic             num_hit;

  // Timeout counters advance and compare against the limit
  assign fmt_inc = st.fmt_timeouts + CNT_W'(1);
  assign enc_inc = st.enc_timeouts + CNT_W'(1);
  assign num_inc = st.num_timeouts + CNT_W'(1);
  assign fmt_hit = (fmt_inc >= timeout_limit);
  assign enc_hit = (enc_inc >= timeout_limit);
  assign num_hit = (num_inc >= timeout_limit);

  // Phase transitions
  always_comb begin
    st_nxt          = st;
    res.cmd_request = REQ_NONE;
    res.event_taken = 1'b0;
    unique case (st.phase)
      PH_INIT: begin
        st_nxt.retries_used = '0;
        st_nxt.sent         = 1'b0;
        st_nxt.phase        = PH_SET_FMT;
      end
      PH_SET_FMT: begin
        res.cmd_request = REQ_SET_FMT;
        if (tick.cmd_accepted) st_nxt.phase = PH_WAIT_FMT;
      end
      PH_WAIT_FMT: begin
        if (tick.event_present) begin
          res.event_taken = 1'b1;
          case (tick.event_code)
            EV_OK: begin
              st_nxt.fmt_timeouts = '0;
              st_nxt.phase        = PH_SET_ENC;
            end
            EV_TIMEOUT: begin
              st_nxt.fmt_timeouts = fmt_hit ? '0 : fmt_inc;
              if (fmt_hit) st_nxt.phase = PH_ERROR;
            end
            EV_ERROR: begin
              st_nxt.fmt_timeouts = '0;
              st_nxt.phase        = PH_ERROR;
            end
            default: st_nxt.phase = PH_ERROR;
          endcase
        end
      end
      PH_SET_ENC: begin
        res.cmd_request = REQ_SET_ENC;
        if (tick.cmd_accepted) st_nxt.phase = PH_WAIT_ENC;
      end
      PH_WAIT_ENC: begin
        if (tick.event_present) begin
          res.event_taken = 1'b1;
          case (tick.event_code)
            EV_OK: begin
              st_nxt.enc_timeouts = '0;
              st_nxt.phase        = PH_SET_NUM;
            end
            EV_TIMEOUT: begin
              st_nxt.enc_timeouts = enc_hit ? '0 : enc_inc;
              if (enc_hit) st_nxt.phase = PH_ERROR;
            end
            EV_ERROR: begin
              st_nxt.enc_timeouts = '0;
              st_nxt.phase        = PH_ERROR;
            end
            default: st_nxt.phase = PH_ERROR;
          endcase
        end
      end
      PH_SET_NUM: begin
        res.cmd_request = REQ_SET_NUM;
        if (tick.cmd_accepted) st_nxt.phase = PH_WAIT_NUM;
      end
      PH_WAIT_NUM: begin
        // unexpected responses are swallowed here
        if (tick.event_present) begin
          res.event_taken = 1'b1;
          case (tick.event_code)
            EV_PROMPT: begin
              st_nxt.num_timeouts = '0;
              st_nxt.phase        = PH_SEND;
            end
            EV_TIMEOUT: begin
              st_nxt.num_timeouts = num_hit ? '0 : num_inc;
              if (num_hit) st_nxt.phase = PH_ERROR;
            end
            EV_ERROR: begin
              st_nxt.num_timeouts = '0;
              st_nxt.phase        = PH_ERROR;
            end
            default: ;
          endcase
        end
      end
      PH_SEND: begin
        // text goes out without waiting for acceptance
        res.cmd_request = REQ_SEND_TXT;
        st_nxt.phase    = PH_WAIT_RES;
      end
      PH_WAIT_RES: begin
        if (tick.event_present) begin
          res.event_taken = 1'b1;
          case (tick.event_code)
            EV_SENT: begin
              st_nxt.sent  = 1'b1;
              st_nxt.phase = PH_DONE;
            end
            EV_TIMEOUT: begin
              if (st.retries_used < retry_limit) begin
                st_nxt.retries_used = st.retries_used + CNT_W'(1);
                st_nxt.phase        = PH_SET_NUM;
              end else begin
                st_nxt.phase = PH_ERROR;
              end
            end
            default: ;
          endcase
        end
      end
      PH_DONE: ;
      default: st_nxt.phase = PH_ERROR;
    endcase

    // Status reflects the state after this tick
    res.phase    = st_nxt.phase;
    res.finished = (st_nxt.phase == PH_DONE) && st_nxt.sent;
    res.failed   = (st_nxt.phase == PH_ERROR);
  end

endmodule

@@ sv/sms_send_command_sequencer_unit.sv @@
// Each result is registered in the output register in the cycle after its tick is taken.
// Throughput: one tick per cycle while the output register is drained; the single-level next-state logic sets the pace.
// in_tready stays high while the output register is empty or being drained this cycle.
// Reset (rst_n low, synchronous): init phase, counters cleared, both limits back to 3,
// output register empty.
`timescale 1ns / 1ps
module sms_send_command_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] event_present, [3:1] event_code, [4] cmd_accepted, [7:5] zero
  input  logic [sms_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] cmd_request, [3] event_taken, [4] finished, [5] failed, [9:6] phase, [15:10] zero
  output logic [sms_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sms_pkg::CFG_W-1:0]         cfg_data
);
  import sms_pkg::*;

  `include "sms_send_command_sequencer_unit_macros.svh"

  sms_regs_t        st_r;
  sms_regs_t        st_nxt;
  sms_tick_t        tick;
  sms_res_t         res;
  logic [CFG_W-1:0] timeout_limit_r;
  logic [CFG_W-1:0] retry_limit_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic             in_fire;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Unpack the tick transaction
  assign tick = sms_tick_t'(in_tdata[$bits(sms_tick_t)-1:0]);

  sms_step u_step (
    .st            (st_r),
    .tick          (tick),
    .timeout_limit (timeout_limit_r),
    .retry_limit   (retry_limit_r),
    .st_nxt        (st_nxt),
    .res           (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_LIMIT_RST;
      retry_limit_r   <= RETRY_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_data;
        CFG_RETRY_LIMIT:   retry_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state advances on every accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {(OUT_TDATA_W - $bits(sms_res_t))'(0), res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `SMS_ASSERT_NOW(a_phase_range, 1'b1, st_r.phase <= PH_ERROR, "phase out of range")
  `SMS_ASSERT_NEXT(a_done_sticks, st_r.phase == PH_DONE, st_r.phase == PH_DONE,
                   "left done state")
  `SMS_ASSERT_NEXT(a_fire_loads, in_fire, out_valid_r, "accepted tick gave no result")
  `SMS_ASSERT_NOW(a_failed_match, out_valid_r,
                  out_data_r[5] == (out_data_r[9:6] == PH_ERROR),
                  "failed flag disagrees with phase")

endmodule
